[src/sea_pkg.sv]
// ----------------------------------------------------------------------------
// Satellite elevation angle package
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sea_pkg;

  localparam int ANGLE_FRAC_BITS = 24;
  localparam int ELEV_W          = ANGLE_FRAC_BITS + 2;

  localparam int IN_W   = 37;
  localparam int DIFF_W = 38;
  localparam int SC_W   = 30;
  localparam int PW     = 62;
  localparam int PM_W   = 31;
  localparam int DOT_W  = 32;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;
  localparam int CW     = 36;

  localparam int SQ_PER_STAGE    = 2;
  localparam int SQ_STAGES       = ROOT_W / SQ_PER_STAGE;
  localparam int STEPS           = 32;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CSTAGES         = STEPS / STEPS_PER_STAGE;

  localparam int RND_SH = 32 - ANGLE_FRAC_BITS;

  localparam logic signed [CW-1:0] HALF_PI_Q32   = 36'sd6746518852;
  localparam logic signed [CW-1:0] HALF_OUT_FULL =
    (HALF_PI_Q32 + (36'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  localparam logic [ELEV_W-1:0]    HALF_OUT      = HALF_OUT_FULL[ELEV_W-1:0];

  localparam logic [79:0] AREA_LIMIT = 80'd1000000000000;

  typedef struct packed {
    logic                    deg;
    logic signed [DOT_W-1:0] dot;
    logic [PM_W-1:0]         cx;
    logic [PM_W-1:0]         cy;
    logic [PM_W-1:0]         cz;
  } sea_pair_t;

  typedef struct packed {
    logic                    deg;
    logic signed [DOT_W-1:0] dot;
    logic [ROOT_W-1:0]       root;
  } sea_vec_t;

  // atan(2^-i) in Q32; from i = 11 on the value is 2^(32-i).
  function automatic logic [CW-1:0] atan_q32(input int unsigned i);
    logic [CW-1:0] a;
    unique case (i)
      0:       a = 36'd3373259426;
      1:       a = 36'd1991351318;
      2:       a = 36'd1052175346;
      3:       a = 36'd534100635;
      4:       a = 36'd268086749;
      5:       a = 36'd134174063;
      6:       a = 36'd67103403;
      7:       a = 36'd33553749;
      8:       a = 36'd16777131;
      9:       a = 36'd8388597;
      10:      a = 36'd4194303;
      default: a = CW'(64'd1 << (32 - i));
    endcase
    return a;
  endfunction

endpackage

[src/sea_prep.sv]
// ----------------------------------------------------------------------------
// Vector preparation
// Line of sight, degenerate test, vector scaling, dot and cross products.
// ----------------------------------------------------------------------------
module sea_prep
  import sea_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic signed [IN_W-1:0] sat_x_i,
  input  logic signed [IN_W-1:0] sat_y_i,
  input  logic signed [IN_W-1:0] sat_z_i,
  input  logic signed [IN_W-1:0] rcv_x_i,
  input  logic signed [IN_W-1:0] rcv_y_i,
  input  logic signed [IN_W-1:0] rcv_z_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output sea_pair_t              pair_o
);

  localparam int NS = 7;

  function automatic logic [3:0] vec_shift(input logic [DIFF_W-1:0] m);
    logic [3:0] s;
    s = '0;
    for (int i = 29; i < DIFF_W; i++) begin
      if (m[i]) s = 4'(i - 28);
    end
    return s;
  endfunction

  function automatic logic [4:0] pair_shift(input logic [PW-1:0] m);
    logic [4:0] s;
    s = '0;
    for (int i = 31; i < PW; i++) begin
      if (m[i]) s = 5'(i - 30);
    end
    return s;
  endfunction

  function automatic logic signed [2*SC_W-1:0] smul(input logic signed [SC_W-1:0] a,
                                                     input logic signed [SC_W-1:0] b);
    logic signed [2*SC_W-1:0] p;
    p = a * b;
    return p;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   st;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  always_comb begin
    st[NS] = stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      st[k] = v_q[k] & st[k+1];
    end
    en   = ~st[NS-1:0];
    v_in = {v_q[NS-2:0], valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign stall_o = st[0];
  assign valid_o = v_q[NS-1];

  // Stage 1: receiver and line of sight.
  logic signed [IN_W-1:0]   s_in [3];
  logic signed [IN_W-1:0]   r_in [3];
  logic signed [IN_W-1:0]   r1_q [3];
  logic signed [DIFF_W-1:0] d1_q [3];

  assign s_in = '{sat_x_i, sat_y_i, sat_z_i};
  assign r_in = '{rcv_x_i, rcv_y_i, rcv_z_i};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        r1_q[i] <= r_in[i];
        d1_q[i] <= DIFF_W'(s_in[i]) - DIFF_W'(r_in[i]);
      end
    end
  end

  // Stage 2: magnitudes and signs.
  logic [DIFF_W-1:0] rm2_q [3];
  logic [DIFF_W-1:0] dm2_q [3];
  logic [2:0]        rs2_q, ds2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        rs2_q[i] <= r1_q[i][IN_W-1];
        ds2_q[i] <= d1_q[i][DIFF_W-1];
        rm2_q[i] <= r1_q[i][IN_W-1] ? DIFF_W'(-DIFF_W'(r1_q[i])) : DIFF_W'(r1_q[i]);
        dm2_q[i] <= d1_q[i][DIFF_W-1] ? DIFF_W'(-d1_q[i]) : DIFF_W'(d1_q[i]);
      end
    end
  end

  // Stage 3: squares for the degenerate test, scaled vectors.
  logic [3:0]             rsh, dsh;
  logic [DIFF_W-1:0]      rt [3];
  logic [DIFF_W-1:0]      dt [3];
  logic signed [SC_W-1:0] rtt [3];
  logic signed [SC_W-1:0] dtt [3];
  logic                   rz3_q, dz3_q, small3_q;
  logic [39:0]            rsq3_q [3];
  logic [39:0]            dsq3_q [3];
  logic signed [SC_W-1:0] r3_q [3];
  logic signed [SC_W-1:0] d3_q [3];

  always_comb begin
    rsh = vec_shift(rm2_q[0] | rm2_q[1] | rm2_q[2]);
    dsh = vec_shift(dm2_q[0] | dm2_q[1] | dm2_q[2]);
    for (int i = 0; i < 3; i++) begin
      rt[i]  = rm2_q[i] >> rsh;
      dt[i]  = dm2_q[i] >> dsh;
      rtt[i] = {1'b0, rt[i][SC_W-2:0]};
      dtt[i] = {1'b0, dt[i][SC_W-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rz3_q    <= ~|(rm2_q[0] | rm2_q[1] | rm2_q[2]);
      dz3_q    <= ~|(dm2_q[0] | dm2_q[1] | dm2_q[2]);
      small3_q <= ~|((rm2_q[0] | rm2_q[1] | rm2_q[2] |
                      dm2_q[0] | dm2_q[1] | dm2_q[2]) >> 20);
      for (int i = 0; i < 3; i++) begin
        rsq3_q[i] <= rm2_q[i][19:0] * rm2_q[i][19:0];
        dsq3_q[i] <= dm2_q[i][19:0] * dm2_q[i][19:0];
        r3_q[i]   <= rs2_q[i] ? -rtt[i] : rtt[i];
        d3_q[i]   <= ds2_q[i] ? -dtt[i] : dtt[i];
      end
    end
  end

  // Stage 4: squared lengths and the nine products.
  logic                     rz4_q, dz4_q, small4_q;
  logic [41:0]              r2_4_q, d2_4_q;
  logic signed [2*SC_W-1:0] pr4_q [9];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      rz4_q    <= rz3_q;
      dz4_q    <= dz3_q;
      small4_q <= small3_q;
      r2_4_q   <= 42'(rsq3_q[0]) + 42'(rsq3_q[1]) + 42'(rsq3_q[2]);
      d2_4_q   <= 42'(dsq3_q[0]) + 42'(dsq3_q[1]) + 42'(dsq3_q[2]);
      pr4_q[0] <= smul(r3_q[0], d3_q[0]);
      pr4_q[1] <= smul(r3_q[1], d3_q[1]);
      pr4_q[2] <= smul(r3_q[2], d3_q[2]);
      pr4_q[3] <= smul(r3_q[1], d3_q[2]);
      pr4_q[4] <= smul(r3_q[2], d3_q[1]);
      pr4_q[5] <= smul(r3_q[2], d3_q[0]);
      pr4_q[6] <= smul(r3_q[0], d3_q[2]);
      pr4_q[7] <= smul(r3_q[0], d3_q[1]);
      pr4_q[8] <= smul(r3_q[1], d3_q[0]);
    end
  end

  // Stage 5: area partial products, dot and cross sums.
  logic                 rz5_q, dz5_q, small5_q, big5_q;
  logic [59:0]          lo5_q, hi5_q;
  logic signed [PW-1:0] v5_q [4];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      rz5_q    <= rz4_q;
      dz5_q    <= dz4_q;
      small5_q <= small4_q;
      big5_q   <= (|r2_4_q[41:40]) | (|d2_4_q[41:40]);
      lo5_q    <= r2_4_q[39:0] * d2_4_q[19:0];
      hi5_q    <= r2_4_q[39:0] * d2_4_q[39:20];
      v5_q[0]  <= PW'(pr4_q[0]) + PW'(pr4_q[1]) + PW'(pr4_q[2]);
      v5_q[1]  <= PW'(pr4_q[3]) - PW'(pr4_q[4]);
      v5_q[2]  <= PW'(pr4_q[5]) - PW'(pr4_q[6]);
      v5_q[3]  <= PW'(pr4_q[7]) - PW'(pr4_q[8]);
    end
  end

  // Stage 6: degenerate decision, magnitudes of the four sums.
  logic          deg6_q;
  logic [PW-1:0] m6_q [4];
  logic          dsg6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      deg6_q <= rz5_q | dz5_q |
                (small5_q & ~big5_q & (({hi5_q, 20'b0} + 80'(lo5_q)) < AREA_LIMIT));
      dsg6_q <= v5_q[0][PW-1];
      for (int i = 0; i < 4; i++) begin
        m6_q[i] <= v5_q[i][PW-1] ? PW'(-v5_q[i]) : PW'(v5_q[i]);
      end
    end
  end

  // Stage 7: common shift of the dot and cross terms.
  logic [4:0]              psh;
  logic [PW-1:0]           pt [4];
  logic signed [DOT_W-1:0] dtt7;

  always_comb begin
    psh = pair_shift(m6_q[0] | m6_q[1] | m6_q[2] | m6_q[3]);
    for (int i = 0; i < 4; i++) begin
      pt[i] = m6_q[i] >> psh;
    end
    dtt7 = {1'b0, pt[0][PM_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pair_o.deg <= deg6_q;
      pair_o.dot <= dsg6_q ? -dtt7 : dtt7;
      pair_o.cx  <= pt[1][PM_W-1:0];
      pair_o.cy  <= pt[2][PM_W-1:0];
      pair_o.cz  <= pt[3][PM_W-1:0];
    end
  end

endmodule

[src/sea_sqrt.sv]
// ----------------------------------------------------------------------------
// Cross product length
// Sum of squares and a pipelined digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module sea_sqrt
  import sea_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  sea_pair_t pair_i,
  output logic      valid_o,
  input  logic      stall_i,
  output sea_vec_t  vec_o
);

  localparam int NS = 2 + SQ_STAGES;

  typedef struct packed {
    logic                    deg;
    logic signed [DOT_W-1:0] dot;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   qs;
  } sq_t;

  function automatic sq_t sq_step(input sq_t a);
    sq_t              b;
    logic [REM_W-1:0] rn;
    logic [REM_W-1:0] tr;
    rn   = {a.rem[REM_W-3:0], a.qs[SQ_W-1 -: 2]};
    tr   = REM_W'({a.root, 2'b01});
    b.qs = a.qs << 2;
    if (rn >= tr) begin
      b.rem  = rn - tr;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = rn;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   st;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  always_comb begin
    st[NS] = stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      st[k] = v_q[k] & st[k+1];
    end
    en   = ~st[NS-1:0];
    v_in = {v_q[NS-2:0], valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign stall_o = st[0];
  assign valid_o = v_q[NS-1];

  side_t           side_q [NS];
  logic [2*PM_W-1:0] sq0_q [3];
  logic [SQ_W-1:0] q1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= '{deg: pair_i.deg, dot: pair_i.dot};
      sq0_q[0]  <= pair_i.cx * pair_i.cx;
      sq0_q[1]  <= pair_i.cy * pair_i.cy;
      sq0_q[2]  <= pair_i.cz * pair_i.cz;
    end
    if (en[1]) begin
      side_q[1] <= side_q[0];
      q1_q      <= SQ_W'(sq0_q[0]) + SQ_W'(sq0_q[1]) + SQ_W'(sq0_q[2]);
    end
  end

  sq_t it_q [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_root
    sq_t it_in;
    sq_t it_out;

    always_comb begin
      if (j == 0) begin
        it_in = '{rem: '0, root: '0, qs: q1_q};
      end else begin
        it_in = it_q[(j == 0) ? 0 : j - 1];
      end
      it_out = it_in;
      for (int n = 0; n < SQ_PER_STAGE; n++) begin
        it_out = sq_step(it_out);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j+2]) begin
        it_q[j]     <= it_out;
        side_q[j+2] <= side_q[j+1];
      end
    end
  end

  assign vec_o.deg  = side_q[NS-1].deg;
  assign vec_o.dot  = side_q[NS-1].dot;
  assign vec_o.root = it_q[SQ_STAGES-1].root;

endmodule

[src/sea_cordic.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Angle of (root, dot) in Q32, then rounding, saturation and output register.
// ----------------------------------------------------------------------------
module sea_cordic
  import sea_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  sea_vec_t                 vec_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [ELEV_W-1:0] elevation_o,
  output logic                     degenerate_o
);

  localparam int NS = CSTAGES + 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cs_t;

  function automatic cs_t cstep(input cs_t a, input int unsigned i);
    cs_t                  b;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    xs = a.x >>> i;
    ys = a.y >>> i;
    at = atan_q32(i);
    if (!a.y[CW-1]) begin
      b.x = a.x + ys;
      b.y = a.y - xs;
      b.z = a.z + at;
    end else begin
      b.x = a.x - ys;
      b.y = a.y + xs;
      b.z = a.z - at;
    end
    return b;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   st;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  always_comb begin
    st[NS] = stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      st[k] = v_q[k] & st[k+1];
    end
    en   = ~st[NS-1:0];
    v_in = {v_q[NS-2:0], valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign stall_o = st[0];
  assign valid_o = v_q[NS-1];

  cs_t  c_q   [CSTAGES];
  logic deg_q [CSTAGES];

  for (genvar k = 0; k < CSTAGES; k++) begin : g_rot
    cs_t  c_in;
    cs_t  c_out;
    logic d_in;

    always_comb begin
      if (k == 0) begin
        c_in = '{x: CW'(vec_i.root), y: CW'(vec_i.dot), z: '0};
        d_in = vec_i.deg;
      end else begin
        c_in = c_q[(k == 0) ? 0 : k - 1];
        d_in = deg_q[(k == 0) ? 0 : k - 1];
      end
      c_out = c_in;
      for (int n = 0; n < STEPS_PER_STAGE; n++) begin
        c_out = cstep(c_out, STEPS_PER_STAGE * k + n);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        c_q[k]   <= c_out;
        deg_q[k] <= d_in;
      end
    end
  end

  // Round half up to the output scale, then clamp to plus or minus pi/2; degenerate beats give pi/2.
  logic signed [CW-1:0] rnd;
  logic [ELEV_W-1:0]    elev_d;

  always_comb begin
    rnd = (c_q[CSTAGES-1].z + (36'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    priority if (deg_q[CSTAGES-1]) begin
      elev_d = HALF_OUT;
    end else if (rnd > HALF_OUT_FULL) begin
      elev_d = HALF_OUT;
    end else if (rnd < -HALF_OUT_FULL) begin
      elev_d = ELEV_W'(-HALF_OUT_FULL);
    end else begin
      elev_d = rnd[ELEV_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      elevation_o  <= elev_d;
      degenerate_o <= deg_q[CSTAGES-1];
    end
  end

endmodule

[src/satellite_elevation_angle.sv]
// ----------------------------------------------------------------------------
// Satellite elevation angle
// Geocentric elevation of a satellite seen from a receiver, both given in
// Earth-centered coordinates in signed millimeters.
// ----------------------------------------------------------------------------
// The block takes one satellite and receiver pair per beat and returns one
// elevation beat for each, in order. The elevation is pi/2 minus the angle
// between the receiver position and the line of sight, evaluated as the
// arctangent of the dot product over the cross product length, so the
// cosine never leaves [-1, 1]. The result is signed radians with
// ANGLE_FRAC_BITS fraction bits, rounded half up and clamped to plus or minus
// pi/2. When the receiver radius times the range is below one square meter,
// the elevation is pi/2 and the degenerate flag is set. The design is a fully
// pipelined datapath that accepts a new beat in every cycle unless stalled; it
// is built from 7 preparation stages (line of sight, vector scaling and
// the dot and cross products), 18 stages of squaring and a square root that
// resolves two root bits per stage, and 16 stages of vectoring CORDIC at two
// rotations per stage followed by the output register. Every stage carries
// its own valid bit and only stalls when the stage after it is full and
// stalled, so bubbles are squeezed out and new beats keep entering while a
// result waits, until every stage holds a beat. Input bits above bit 36 do
// not exist on the ports.
module satellite_elevation_angle
  import sea_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [IN_W-1:0]   sat_x_i,
  input  logic signed [IN_W-1:0]   sat_y_i,
  input  logic signed [IN_W-1:0]   sat_z_i,
  input  logic signed [IN_W-1:0]   rcv_x_i,
  input  logic signed [IN_W-1:0]   rcv_y_i,
  input  logic signed [IN_W-1:0]   rcv_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ELEV_W-1:0] elevation_o,
  output logic                     degenerate_o
);

  // Preparation to square root handshake and payload.
  logic      prep_valid;
  logic      prep_stall;
  sea_pair_t prep_pair;

  // Square root to CORDIC handshake and payload.
  logic      root_valid;
  logic      root_stall;
  sea_vec_t  root_vec;

  // Scaled line of sight and receiver, then the dot and cross products.
  sea_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .sat_x_i (sat_x_i),
    .sat_y_i (sat_y_i),
    .sat_z_i (sat_z_i),
    .rcv_x_i (rcv_x_i),
    .rcv_y_i (rcv_y_i),
    .rcv_z_i (rcv_z_i),
    .valid_o (prep_valid),
    .stall_i (prep_stall),
    .pair_o  (prep_pair)
  );

  // Length of the cross product.
  sea_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .stall_o (prep_stall),
    .pair_i  (prep_pair),
    .valid_o (root_valid),
    .stall_i (root_stall),
    .vec_o   (root_vec)
  );

  // Angle of (length, dot), rounding and the output register.
  sea_cordic u_cordic (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (root_valid),
    .stall_o      (root_stall),
    .vec_i        (root_vec),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .elevation_o  (elevation_o),
    .degenerate_o (degenerate_o)
  );

endmodule

[src/sea_checker.sv]
// ----------------------------------------------------------------------------
// Satellite elevation angle checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sea_checker
  import sea_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic signed [IN_W-1:0]   sat_x_i,
  input logic signed [IN_W-1:0]   sat_y_i,
  input logic signed [IN_W-1:0]   sat_z_i,
  input logic signed [IN_W-1:0]   rcv_x_i,
  input logic signed [IN_W-1:0]   rcv_y_i,
  input logic signed [IN_W-1:0]   rcv_z_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [ELEV_W-1:0] elevation_o,
  input logic                     degenerate_o
);

  localparam logic signed [ELEV_W-1:0] HALF_S = HALF_OUT;

  // A held result beat stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // The input side only stalls when the whole pipe backs up from the output.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Degenerate geometry always reports pi/2.
  a_deg_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> elevation_o == HALF_S)
    else $error("degenerate beat without pi/2 elevation");

  // The elevation never leaves plus or minus pi/2.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (elevation_o <= HALF_S) && (elevation_o >= -HALF_S))
    else $error("elevation out of range");

endmodule

bind satellite_elevation_angle sea_checker u_sea_checker (.*);

[tb/tb_satellite_elevation_angle.sv]
// ----------------------------------------------------------------------------
// Satellite elevation angle testbench
// Drives satellite and receiver positions with random gaps and stalls, and
// checks each elevation beat against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_satellite_elevation_angle;
  import sea_pkg::*;

  localparam int LATENCY   = 42;
  localparam int WATCHDOG  = 2000;
  localparam int N_RANDOM  = 400;

  typedef struct {
    logic signed [ELEV_W-1:0] elevation;
    logic                     degenerate;
  } elev_beat_t;

  // Magnitude of a signed value, as an unsigned 64-bit number.
  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // Shift the magnitude toward zero while keeping the sign.
  function automatic longint trunc_shift(longint v, int s);
    longint unsigned m;
    m = abs64(v) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic int norm_shift(longint unsigned m, longint unsigned lim);
    int s;
    s = 0;
    while (s < 63 && (m >> s) >= lim) s++;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned q);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= res + b) begin
        q -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Whether radius times range falls below one square meter.
  function automatic bit too_close(longint r[3], longint d[3]);
    longint unsigned r2, d2, lim;
    r2 = 0;
    d2 = 0;
    if ((r[0] == 0 && r[1] == 0 && r[2] == 0) || (d[0] == 0 && d[1] == 0 && d[2] == 0))
      return 1;
    for (int i = 0; i < 3; i++)
      if (abs64(r[i]) >= (64'd1 << 20) || abs64(d[i]) >= (64'd1 << 20)) return 0;
    for (int i = 0; i < 3; i++) begin
      r2 += abs64(r[i]) * abs64(r[i]);
      d2 += abs64(d[i]) * abs64(d[i]);
    end
    lim = (64'd1000000000000 + r2 - 1) / r2;
    return d2 < lim;
  endfunction

  function automatic elev_beat_t elevation_of(logic signed [IN_W-1:0] sat[3],
                                              logic signed [IN_W-1:0] rcv[3]);
    elev_beat_t res;
    longint r[3], d[3], v[4], x, y, z, xs, ys, half, e;
    longint unsigned m;
    int s;
    half = 64'sd26353589;
    half = (64'sd6746518852 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'(rcv[i]);
      d[i] = longint'(sat[i]) - r[i];
    end
    res.degenerate = too_close(r, d);
    if (res.degenerate) begin
      res.elevation = half[ELEV_W-1:0];
      return res;
    end
    m = abs64(r[0]);
    if (abs64(r[1]) > m) m = abs64(r[1]);
    if (abs64(r[2]) > m) m = abs64(r[2]);
    s = norm_shift(m, 64'd1 << 29);
    for (int i = 0; i < 3; i++) r[i] = trunc_shift(r[i], s);
    m = abs64(d[0]);
    if (abs64(d[1]) > m) m = abs64(d[1]);
    if (abs64(d[2]) > m) m = abs64(d[2]);
    s = norm_shift(m, 64'd1 << 29);
    for (int i = 0; i < 3; i++) d[i] = trunc_shift(d[i], s);
    v[0] = r[0] * d[0] + r[1] * d[1] + r[2] * d[2];
    v[1] = r[1] * d[2] - r[2] * d[1];
    v[2] = r[2] * d[0] - r[0] * d[2];
    v[3] = r[0] * d[1] - r[1] * d[0];
    m = 0;
    for (int i = 0; i < 4; i++) if (abs64(v[i]) > m) m = abs64(v[i]);
    s = norm_shift(m, 64'd1 << 31);
    for (int i = 0; i < 4; i++) v[i] = trunc_shift(v[i], s);
    x = longint'(int_sqrt(abs64(v[1]) * abs64(v[1]) + abs64(v[2]) * abs64(v[2])
                          + abs64(v[3]) * abs64(v[3])));
    y = v[0];
    z = 0;
    // Vectoring rotations drive y toward zero while z collects the angle.
    for (int i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += longint'(atan_q32(i));
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(atan_q32(i));
      end
    end
    e = (z + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    if (e > half) e = half;
    if (e < -half) e = -half;
    res.elevation = e[ELEV_W-1:0];
    return res;
  endfunction

  // Holds the elevations still owed by the block, oldest first.
  class elevation_scoreboard;
    elev_beat_t pending[$];
    int errors;

    function void note_pair(logic signed [IN_W-1:0] sat[3],
                            logic signed [IN_W-1:0] rcv[3]);
      pending.insert(pending.size(), elevation_of(sat, rcv));
    endfunction

    function void check_beat(logic signed [ELEV_W-1:0] elev, logic deg);
      elev_beat_t exp_b;
      if (pending.size() == 0) begin
        $error("elevation beat with nothing pending: %0d", elev);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (elev !== exp_b.elevation) begin
        $error("elevation: expected %0d, got %0d", exp_b.elevation, elev);
        errors++;
      end
      if (deg !== exp_b.degenerate) begin
        $error("degenerate: expected %0d, got %0d", exp_b.degenerate, deg);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [IN_W-1:0] sat_x_i = '0, sat_y_i = '0, sat_z_i = '0;
  logic signed [IN_W-1:0] rcv_x_i = '0, rcv_y_i = '0, rcv_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [ELEV_W-1:0] elevation_o;
  logic degenerate_o;

  elevation_scoreboard board = new();
  int idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  satellite_elevation_angle u_top (.*);

  // The watchdog counts cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: check every accepted beat, and stall at random.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      board.check_beat(elevation_o, degenerate_o);
      // Long unstalled stretches are mixed in by checking every valid beat for a random stretch with the stall low.
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(0, 20)) begin
          @(posedge clk_i);
          if (out_valid_o) board.check_beat(elevation_o, degenerate_o);
        end
      end
    end
  end

  // Sends one pair; returns after the beat has been accepted.
  task automatic send_pair(logic signed [IN_W-1:0] sat[3], logic signed [IN_W-1:0] rcv[3],
                           bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sat_x_i <= sat[0];
    sat_y_i <= sat[1];
    sat_z_i <= sat[2];
    rcv_x_i <= rcv[0];
    rcv_y_i <= rcv[1];
    rcv_z_i <= rcv[2];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_pair(sat, rcv);
  endtask

  function automatic logic signed [IN_W-1:0] rand_coord(int kind);
    logic signed [IN_W-1:0] v;
    case (kind)
      0: v = IN_W'({$urandom, $urandom});
      1: v = $signed(IN_W'($urandom_range(0, 4000000))) - 2000000;
      2: v = $urandom_range(0, 1) ? {1'b1, 36'd0} : {1'b0, {36{1'b1}}};
      default: v = $signed(IN_W'($urandom_range(0, 60000000))) - 30000000;
    endcase
    return v;
  endfunction

  initial begin
    logic signed [IN_W-1:0] sat[3], rcv[3];
    logic signed [IN_W-1:0] lo, hi;
    int kind;
    bit burst;
    lo = {1'b1, 36'd0};
    hi = {1'b0, {36{1'b1}}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs: both zero, zenith, nadir, tiny ranges, and field extremes.
    sat = '{0, 0, 0}; rcv = '{0, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{0, 0, 37'sd30000000000}; rcv = '{0, 0, 37'sd6371000000}; send_pair(sat, rcv, 0);
    sat = '{0, 0, -37'sd30000000000}; rcv = '{0, 0, 37'sd6371000000}; send_pair(sat, rcv, 1);
    sat = '{37'sd6371000000, 0, 0}; rcv = '{37'sd6371000000, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{1000, 0, 0}; rcv = '{1000, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{1001, 0, 0}; rcv = '{1000, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{1000, 1000, 0}; rcv = '{1000, 0, 0}; send_pair(sat, rcv, 1);
    sat = '{1000000, 1000000, 0}; rcv = '{1000000, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{2000, 0, 0}; rcv = '{1000, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{999, 0, 0}; rcv = '{1000, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{hi, hi, hi}; rcv = '{lo, lo, lo}; send_pair(sat, rcv, 0);
    sat = '{lo, lo, lo}; rcv = '{hi, hi, hi}; send_pair(sat, rcv, 1);
    sat = '{hi, lo, hi}; rcv = '{hi, hi, lo}; send_pair(sat, rcv, 0);
    sat = '{lo, 0, 0}; rcv = '{-1, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{0, hi, 0}; rcv = '{1, 0, 0}; send_pair(sat, rcv, 0);
    sat = '{-1, -1, -1}; rcv = '{-1, -1, -1}; send_pair(sat, rcv, 0);
    sat = '{37'sd20000000000, 37'sd10000000000, 37'sd15000000000};
    rcv = '{37'sd4000000000, 37'sd3000000000, 37'sd3500000000}; send_pair(sat, rcv, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 3);
      burst = $urandom_range(0, 3) == 0;
      for (int i = 0; i < 3; i++) begin
        rcv[i] = rand_coord(kind);
        // Mostly nearby satellites so small ranges and sign changes show up.
        sat[i] = $urandom_range(0, 2) == 0 ? rand_coord($urandom_range(0, 3))
                                           : rcv[i] + rand_coord(1);
      end
      send_pair(sat, rcv, burst);
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
